### hdl/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

	localparam int WORD_BITS = 32;
	localparam int WORD_SHIFT = 5;
	localparam int FRAME_W = 12;
	localparam int FRAME_COUNT_DEF = 4096;
	localparam logic [WORD_BITS-1:0] ALL_USED = '1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_HAD_FRAME = 3'd1,
		ST_NO_FRAME = 3'd2,
		ST_FREED = 3'd3,
		ST_NOTHING = 3'd4
	} status_t;

	typedef struct packed {
		logic func;
		logic [FRAME_W-1:0] entry_frame;
		logic kernel_page;
		logic write_enable;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [FRAME_W-1:0] new_frame;
		logic present;
		logic writable;
		logic user_mode;
	} rsp_t;

endpackage

### hdl/fba_ram.sv
`timescale 1ns / 1ps

module fba_ram
	import fba_pkg::*;
#(
	parameter int WIDTH = WORD_BITS,
	parameter int DEPTH = FRAME_COUNT_DEF / WORD_BITS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/frame_bitmap_allocator.sv
`timescale 1ns / 1ps

// First-fit page-frame allocator over a used/free bitmap held in one RAM, 32 frames
// to a word. After reset the block clears every word of the bitmap and takes no
// request until that is done. An allocate request with an empty entry reads the
// bitmap one word per cycle from word 0 through the single read port and stops at
// the first word with a free bit, or at the last word if none is free. A free
// request of a frame inside the bitmap does a read-modify-write of its word. One
// request is in work at a time; a finished response waits in an output register
// while the next request is already taken.
module frame_bitmap_allocator
	import fba_pkg::*;
#(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp
);

	localparam int WORD_COUNT = FRAME_COUNT / WORD_BITS;
	localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_RESULT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] chk_addr_s1;
	req_t req_q;
	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [WORD_BITS-1:0] rd_word;

	logic [WORD_BITS-1:0] free_mask;
	logic [WORD_SHIFT-1:0] bit_idx;
	logic word_full;
	logic scan_last;
	logic [31:0] free_word;
	logic free_in_range;
	logic [AW-1:0] free_addr;
	logic [31:0] frame_wide;
	logic [WORD_BITS-1:0] clr_bit;

	fba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_bitmap (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(rd_word)
	);

	always_comb begin
		free_mask = ~rd_word & (rd_word + WORD_BITS'(1));
		bit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (free_mask[i]) begin
				bit_idx = bit_idx | WORD_SHIFT'(i);
			end
		end
		word_full = (rd_word == ALL_USED);
		scan_last = (chk_addr_s1 == LAST_ADDR);
		frame_wide = (32'(chk_addr_s1) << WORD_SHIFT) | 32'(bit_idx);
		free_word = 32'(req.entry_frame) >> WORD_SHIFT;
		free_in_range = (free_word < 32'(WORD_COUNT));
		free_addr = AW'(free_word);
		clr_bit = WORD_BITS'(1) << req_q.entry_frame[WORD_SHIFT-1:0];
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = chk_addr_s1;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
			end
			S_IDLE: begin
				if (req_valid && req.func == FUNC_ALLOC && req.entry_frame == '0) begin
					ram_re = 1'b1;
				end else if (req_valid && req.func == FUNC_FREE && req.entry_frame != '0
						&& free_in_range) begin
					ram_re = 1'b1;
					ram_raddr = free_addr;
				end
			end
			S_SCAN: begin
				if (!word_full) begin
					ram_we = 1'b1;
					ram_wdata = rd_word | free_mask;
				end else if (!scan_last) begin
					ram_re = 1'b1;
					ram_raddr = chk_addr_s1 + AW'(1);
				end
			end
			S_FREE: begin
				ram_we = 1'b1;
				ram_wdata = rd_word & ~clr_bit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			chk_addr_s1 <= '0;
			req_q <= '0;
			res_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && (!rsp_valid_q || rsp_ready)) begin
				rsp_q <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						if (req.func == FUNC_ALLOC) begin
							if (req.entry_frame != '0) begin
								res_q <= '{ST_HAD_FRAME, req.entry_frame, 1'b0, 1'b0, 1'b0};
								state_q <= S_RESULT;
							end else begin
								res_q <= '0;
								chk_addr_s1 <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							if (req.entry_frame == '0) begin
								res_q <= '{ST_NOTHING, '0, 1'b0, 1'b0, 1'b0};
								state_q <= S_RESULT;
							end else if (free_in_range) begin
								res_q <= '0;
								chk_addr_s1 <= free_addr;
								state_q <= S_FREE;
							end else begin
								res_q <= '{ST_FREED, '0, 1'b0, 1'b0, 1'b0};
								state_q <= S_RESULT;
							end
						end
					end
				end
				S_SCAN: begin
					if (!word_full) begin
						res_q.status <= ST_ALLOCATED;
						res_q.new_frame <= frame_wide[FRAME_W-1:0];
						res_q.present <= 1'b1;
						res_q.writable <= req_q.write_enable;
						res_q.user_mode <= ~req_q.kernel_page;
						state_q <= S_RESULT;
					end else if (scan_last) begin
						res_q.status <= ST_NO_FRAME;
						state_q <= S_RESULT;
					end else begin
						chk_addr_s1 <= chk_addr_s1 + AW'(1);
					end
				end
				S_FREE: begin
					res_q.status <= ST_FREED;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in work");

	a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !rsp_valid)
		else $error("response during the clearing pass");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (chk_addr_s1 <= LAST_ADDR))
		else $error("scan beyond the last bitmap word");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("bitmap read and write to one word in one cycle");

	a_alloc_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_ALLOCATED) |-> (!rsp.present && !rsp.writable
		&& !rsp.user_mode))
		else $error("entry flags set on a response that allocated nothing");
`endif

endmodule
